// ----- design/assert_macros.svh -----
// Assertion helpers included by the detector RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/wmsa_pkg.sv -----
package wmsa_pkg;

  localparam int STAMP_W = 48;
  localparam int PRICE_W = 24;
  localparam int SAMPLE_W = STAMP_W + PRICE_W;

  // Register map
  localparam logic REG_WINDOW_MS = 1'b0;
  localparam logic REG_MIN_COUNT = 1'b1;

  localparam logic [31:0] WINDOW_MS_RESET = 32'd60000;
  localparam logic [8:0]  MIN_COUNT_RESET = 9'd20;

  // Largest variance term whose 9x still fits in 64 bits (2^64-1)/9
  localparam logic [63:0] VAR_LIMIT = 64'h1C71_C71C_71C7_1C71;

  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [3:0]          symbol_id;
    logic [STAMP_W-1:0]  stamp_ms;
    logic [PRICE_W-1:0]  price_cents;
  } in_item_t;

  typedef struct packed {
    logic [8:0]          sample_count;
    logic [PRICE_W-1:0]  mean_cents;
    logic                anomaly;
    logic                overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_RD_OLD,
    S_CHK_OLD,
    S_DROP,
    S_APPEND,
    S_APP_ADD,
    S_WB,
    S_MUL,
    S_DECIDE,
    S_DIV_INIT,
    S_DIV,
    S_DONE
  } state_t;

  // Which 64-bit product the shared multiplier is building
  typedef enum logic [1:0] {
    MOP_NP,
    MOP_NQ,
    MOP_SS,
    MOP_AA
  } mul_op_t;

endpackage

// ----- design/windowed_mean_sigma_anomaly.sv -----
// Windowed mean and three-sigma outlier detector, one sample ring per symbol.
// Requests arrive on in_valid/in_ready with an in_item_t payload; every request
// yields exactly one out_item_t on out_valid/out_ready, in order.
// mode 0 appends (stamp, price) to the symbol ring, drops the oldest sample if
// the ring is full, then evicts samples older than window_ms from the old end.
// mode 1 leaves the ring alone and tests price > mean + 3 sigma exactly.
// Work is done one request at a time by a sequencer around two memories:
// the per-symbol state memory and the sample memory, both with registered reads.
// A push reads and tests old samples one at a time: the oldest of a full
// ring, then each candidate for eviction. A check builds four products on one
// 32x32 multiplier and flags only with at least min_count samples. Both end in
// a bit-serial divide of the sum by the count, one quotient bit a cycle, of
// 24 + clog2(RING_DEPTH+1) steps. Requests are taken only in the idle state.
// Results sit in an output register; the next request is taken while a result
// waits, and a stalled receiver only holds the block once a second result is
// ready. After reset a clearing pass over all NUM_SYMBOLS entries zeroes the
// symbol state; no request is taken during it, configuration writes are.
// Configuration is an APB-style port: 0x0 window_ms, 0x4 min_count.
module windowed_mean_sigma_anomaly #(
  parameter int NUM_SYMBOLS = 16,
  parameter int RING_DEPTH  = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  wmsa_pkg::in_item_t    in_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output wmsa_pkg::out_item_t   out_rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

`include "assert_macros.svh"

  localparam int SYM_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = wmsa_pkg::PRICE_W + CNT_W;
  localparam int SQ_W   = 2 * wmsa_pkg::PRICE_W + CNT_W;
  localparam int ADDR_W = $clog2(NUM_SYMBOLS * RING_DEPTH);
  localparam int DIVC_W = $clog2(SUM_W);

  typedef struct packed {
    logic [IDX_W-1:0] head;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sqsum;
  } sym_state_t;

  // symbol_id modulo NUM_SYMBOLS, worked out at elaboration
  function automatic logic [16*SYM_W-1:0] build_sym_map();
    logic [16*SYM_W-1:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) begin
      m[i*SYM_W +: SYM_W] = SYM_W'(i % NUM_SYMBOLS);
    end
    return m;
  endfunction

  localparam logic [16*SYM_W-1:0] SYM_MAP = build_sym_map();

  // Configuration registers
  logic [31:0] window_ms;
  logic [8:0]  min_count;

  // Memories
  sym_state_t                       sym_mem [NUM_SYMBOLS];
  logic [wmsa_pkg::SAMPLE_W-1:0]    smp_mem [NUM_SYMBOLS * RING_DEPTH];
  sym_state_t                       sym_rd_data;
  logic [wmsa_pkg::SAMPLE_W-1:0]    smp_rd_data;

  logic                             sym_we, sym_re, smp_we, smp_re;
  logic [SYM_W-1:0]                 sym_waddr, sym_raddr;
  sym_state_t                       sym_wdata;
  logic [ADDR_W-1:0]                smp_waddr, smp_raddr;

  // Control and working registers
  wmsa_pkg::state_t                 state, state_next;
  wmsa_pkg::mul_op_t                mul_op;
  logic [1:0]                       mstep;
  logic [SYM_W-1:0]                 clr_idx;
  wmsa_pkg::in_item_t               item;
  logic [SYM_W-1:0]                 sym_r;
  logic [ADDR_W-1:0]                base;
  logic [IDX_W-1:0]                 h_r;
  logic [CNT_W-1:0]                 n_r;
  logic [SUM_W-1:0]                 s_r;
  logic [SQ_W-1:0]                  q_r;
  logic                             evicting, ovf, anom;
  logic [wmsa_pkg::PRICE_W-1:0]     old_p;
  logic [63:0]                      prod, acc, np, nq, a_r, d_r;
  logic [CNT_W:0]                   div_rem;
  logic [SUM_W-1:0]                 div_q;
  logic [DIVC_W-1:0]                div_cnt;

  // Datapath helpers
  logic [31:0]                      mul_a, mul_b;
  logic [63:0]                      mx, my, mul_res;
  logic [CNT_W:0]                   tail_sum;
  logic [IDX_W-1:0]                 tail, h_inc;
  logic [wmsa_pkg::STAMP_W-1:0]     old_stamp;
  logic [wmsa_pkg::PRICE_W-1:0]     old_price;
  logic                             too_old, drop_now;
  logic [CNT_W:0]                   rem_sh;
  logic                             rem_ge;
  logic [63:0]                      var9;
  logic                             out_load;
  logic                             accept;

  assign accept    = in_valid && in_ready;
  assign pready    = 1'b1;
  assign old_stamp = smp_rd_data[wmsa_pkg::SAMPLE_W-1 -: wmsa_pkg::STAMP_W];
  assign old_price = smp_rd_data[wmsa_pkg::PRICE_W-1:0];

  // Config write and readback
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= wmsa_pkg::WINDOW_MS_RESET;
      min_count <= wmsa_pkg::MIN_COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        wmsa_pkg::REG_WINDOW_MS: window_ms <= pwdata;
        wmsa_pkg::REG_MIN_COUNT: min_count <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      wmsa_pkg::REG_WINDOW_MS: prdata = window_ms;
      wmsa_pkg::REG_MIN_COUNT: prdata = {23'd0, min_count};
      default:                 prdata = '0;
    endcase
  end

  // Symbol state memory
  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_waddr] <= sym_wdata;
    if (sym_re) sym_rd_data <= sym_mem[sym_raddr];
  end

  // Sample memory: {stamp, price}
  always_ff @(posedge clk) begin
    if (smp_we) smp_mem[smp_waddr] <= {item.stamp_ms, item.price_cents};
    if (smp_re) smp_rd_data <= smp_mem[smp_raddr];
  end

  // Ring index arithmetic
  always_comb begin
    tail_sum = (CNT_W+1)'(h_r) + (CNT_W+1)'(n_r);
    tail = (tail_sum >= (CNT_W+1)'(RING_DEPTH)) ?
           IDX_W'(tail_sum - (CNT_W+1)'(RING_DEPTH)) : IDX_W'(tail_sum);
    h_inc = (h_r == IDX_W'(RING_DEPTH - 1)) ? '0 : h_r + 1'b1;
  end

  // Age test for the oldest sample
  always_comb begin
    too_old  = (item.stamp_ms >= old_stamp) &&
               ((item.stamp_ms - old_stamp) > {16'd0, window_ms});
    drop_now = !evicting || too_old;
  end

  // 64-bit operand pick for the modular product sequence
  always_comb begin
    case (mul_op)
      wmsa_pkg::MOP_NP: begin
        mx = 64'(n_r);
        my = 64'(item.price_cents);
      end
      wmsa_pkg::MOP_NQ: begin
        mx = 64'(n_r);
        my = 64'(q_r);
      end
      wmsa_pkg::MOP_SS: begin
        mx = 64'(s_r);
        my = 64'(s_r);
      end
      default: begin
        mx = a_r;
        my = a_r;
      end
    endcase
  end

  // Shared 32x32 multiplier operands
  always_comb begin
    mul_a = {8'd0, item.price_cents};
    mul_b = {8'd0, item.price_cents};
    if (state == wmsa_pkg::S_CHK_OLD) begin
      mul_a = {8'd0, old_price};
      mul_b = {8'd0, old_price};
    end else if (state == wmsa_pkg::S_MUL) begin
      mul_a = (mstep == 2'd2) ? mx[63:32] : mx[31:0];
      mul_b = (mstep == 2'd1) ? my[63:32] : my[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Final partial product lands here on the last step
  assign mul_res = acc + {prod[31:0], 32'd0};

  // Divider step and 9x variance
  always_comb begin
    rem_sh = {div_rem[CNT_W-1:0], div_q[SUM_W-1]};
    rem_ge = rem_sh >= (CNT_W+1)'(n_r);
    var9   = {d_r[60:0], 3'd0} + d_r;
  end

  assign out_load = (state == wmsa_pkg::S_DONE) && (!out_valid || out_ready);

  // Sequencer: next state and memory controls
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    sym_we     = 1'b0;
    sym_waddr  = sym_r;
    sym_wdata  = '{head: h_r, count: n_r, sum: s_r, sqsum: q_r};
    sym_re     = 1'b0;
    sym_raddr  = SYM_MAP[in_req.symbol_id*SYM_W +: SYM_W];
    smp_we     = 1'b0;
    smp_waddr  = base + ADDR_W'(tail);
    smp_re     = 1'b0;
    smp_raddr  = base + ADDR_W'(h_r);
    unique case (state)
      wmsa_pkg::S_CLEAR: begin
        sym_we    = 1'b1;
        sym_waddr = clr_idx;
        sym_wdata = '0;
        if (clr_idx == SYM_W'(NUM_SYMBOLS - 1)) state_next = wmsa_pkg::S_IDLE;
      end
      wmsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        sym_re   = 1'b1;
        if (in_valid) state_next = wmsa_pkg::S_LOAD;
      end
      wmsa_pkg::S_LOAD: begin
        if (item.mode == wmsa_pkg::MODE_CHECK) begin
          state_next = wmsa_pkg::S_MUL;
        end else if (sym_rd_data.count >= CNT_W'(RING_DEPTH)) begin
          state_next = wmsa_pkg::S_RD_OLD;
        end else begin
          state_next = wmsa_pkg::S_APPEND;
        end
      end
      wmsa_pkg::S_RD_OLD: begin
        smp_re     = 1'b1;
        state_next = wmsa_pkg::S_CHK_OLD;
      end
      wmsa_pkg::S_CHK_OLD: begin
        state_next = drop_now ? wmsa_pkg::S_DROP : wmsa_pkg::S_WB;
      end
      wmsa_pkg::S_DROP: begin
        if (!evicting)          state_next = wmsa_pkg::S_APPEND;
        else if (n_r != CNT_W'(1)) state_next = wmsa_pkg::S_RD_OLD;
        else                    state_next = wmsa_pkg::S_WB;
      end
      wmsa_pkg::S_APPEND: begin
        smp_we     = 1'b1;
        state_next = wmsa_pkg::S_APP_ADD;
      end
      wmsa_pkg::S_APP_ADD: state_next = wmsa_pkg::S_RD_OLD;
      wmsa_pkg::S_WB: begin
        sym_we     = 1'b1;
        state_next = wmsa_pkg::S_DIV_INIT;
      end
      wmsa_pkg::S_MUL: begin
        if (mstep == 2'd3 && mul_op == wmsa_pkg::MOP_AA) state_next = wmsa_pkg::S_DECIDE;
      end
      wmsa_pkg::S_DECIDE:   state_next = wmsa_pkg::S_DIV_INIT;
      wmsa_pkg::S_DIV_INIT: state_next = wmsa_pkg::S_DIV;
      wmsa_pkg::S_DIV: begin
        if (div_cnt == DIVC_W'(SUM_W - 1)) state_next = wmsa_pkg::S_DONE;
      end
      wmsa_pkg::S_DONE: begin
        if (out_load) state_next = wmsa_pkg::S_IDLE;
      end
      default: state_next = wmsa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= wmsa_pkg::S_CLEAR;
    else     state <= state_next;
  end

  // Control counters and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == wmsa_pkg::S_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    case (state)
      wmsa_pkg::S_IDLE: begin
        if (accept) begin
          item  <= in_req;
          sym_r <= sym_raddr;
          base  <= ADDR_W'(sym_raddr * RING_DEPTH);
        end
      end
      wmsa_pkg::S_LOAD: begin
        h_r      <= sym_rd_data.head;
        n_r      <= sym_rd_data.count;
        s_r      <= sym_rd_data.sum;
        q_r      <= sym_rd_data.sqsum;
        evicting <= 1'b0;
        anom     <= 1'b0;
        ovf      <= (item.mode == wmsa_pkg::MODE_PUSH) &&
                    (sym_rd_data.count >= CNT_W'(RING_DEPTH));
        mul_op   <= wmsa_pkg::MOP_NP;
        mstep    <= 2'd0;
      end
      wmsa_pkg::S_CHK_OLD: old_p <= old_price;
      wmsa_pkg::S_DROP: begin
        s_r <= s_r - SUM_W'(old_p);
        q_r <= q_r - SQ_W'(prod[2*wmsa_pkg::PRICE_W-1:0]);
        h_r <= h_inc;
        n_r <= n_r - 1'b1;
      end
      wmsa_pkg::S_APP_ADD: begin
        s_r      <= s_r + SUM_W'(item.price_cents);
        q_r      <= q_r + SQ_W'(prod[2*wmsa_pkg::PRICE_W-1:0]);
        n_r      <= n_r + 1'b1;
        evicting <= 1'b1;
      end
      // Product mod 2^64 from three 32x32 partials, low word first
      wmsa_pkg::S_MUL: begin
        case (mstep)
          2'd0: mstep <= 2'd1;
          2'd1: begin
            acc   <= prod;
            mstep <= 2'd2;
          end
          2'd2: begin
            acc   <= mul_res;
            mstep <= 2'd3;
          end
          default: begin
            mstep <= 2'd0;
            case (mul_op)
              wmsa_pkg::MOP_NP: begin
                np     <= mul_res;
                mul_op <= wmsa_pkg::MOP_NQ;
              end
              wmsa_pkg::MOP_NQ: begin
                nq     <= mul_res;
                mul_op <= wmsa_pkg::MOP_SS;
              end
              wmsa_pkg::MOP_SS: begin
                d_r    <= nq - mul_res;
                a_r    <= np - 64'(s_r);
                mul_op <= wmsa_pkg::MOP_AA;
              end
              default: acc <= mul_res;
            endcase
          end
        endcase
      end
      // acc holds (n*p - S)^2 mod 2^64 here
      wmsa_pkg::S_DECIDE: begin
        anom <= ((CNT_W+9)'(n_r) >= (CNT_W+9)'(min_count)) &&
                (np > 64'(s_r)) && (d_r <= wmsa_pkg::VAR_LIMIT) && (acc > var9);
      end
      wmsa_pkg::S_DIV_INIT: begin
        div_rem <= '0;
        div_q   <= s_r;
        div_cnt <= '0;
      end
      // Restoring divide, one quotient bit per cycle
      wmsa_pkg::S_DIV: begin
        div_rem <= rem_ge ? rem_sh - (CNT_W+1)'(n_r) : rem_sh;
        div_q   <= {div_q[SUM_W-2:0], rem_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_rsp.sample_count <= 9'(n_r);
      out_rsp.mean_cents   <= (n_r == '0) ? '0 : wmsa_pkg::PRICE_W'(div_q);
      out_rsp.anomaly      <= anom;
      out_rsp.overflow     <= ovf;
    end
  end

  // Checks
  `ASSERT_IMPL(a_wb_count, state == wmsa_pkg::S_WB, n_r <= CNT_W'(RING_DEPTH), "ring count above depth at write-back")
  `ASSERT_IMPL(a_append_room, smp_we, n_r < CNT_W'(RING_DEPTH), "append into a full ring")
  `ASSERT_NEXT(a_accept_load, accept, state == wmsa_pkg::S_LOAD, "accepted request did not start a load")

endmodule
